FILE: hw/rtl/pve_pkg.sv
// ----------------------------------------------------------------------------
// pve_pkg
// shared types, codes and markers of the value stream encoder
// ----------------------------------------------------------------------------
package pve_pkg;

  localparam int unsigned CmdWidth     = 4;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned MaxBytes     = 9;
  localparam int unsigned WordWidth    = MaxBytes * ByteWidth;
  localparam int unsigned CntWidth     = 4;
  localparam int unsigned InDataWidth  = 184;
  localparam int unsigned OutDataWidth = 8;
  localparam int unsigned QueueDepth   = 2;

  // token kinds
  typedef enum logic [CmdWidth-1:0] {
    CMD_NULL   = 4'd0,
    CMD_BOOL   = 4'd1,
    CMD_INT    = 4'd2,
    CMD_FLOAT  = 4'd3,
    CMD_STRING = 4'd4,
    CMD_BYTES  = 4'd5,
    CMD_LIST   = 4'd6,
    CMD_MAP    = 4'd7,
    CMD_STRUCT = 4'd8,
    CMD_RAW    = 4'd9
  } cmd_e;

  // marker bytes
  localparam logic [7:0] MrkNull    = 8'hC0;
  localparam logic [7:0] MrkFloat   = 8'hC1;
  localparam logic [7:0] MrkFalse   = 8'hC2;
  localparam logic [7:0] MrkTrue    = 8'hC3;
  localparam logic [7:0] MrkInt8    = 8'hC8;
  localparam logic [7:0] MrkInt16   = 8'hC9;
  localparam logic [7:0] MrkInt32   = 8'hCA;
  localparam logic [7:0] MrkInt64   = 8'hCB;
  localparam logic [7:0] MrkBytes8  = 8'hCC;
  localparam logic [7:0] MrkBytes16 = 8'hCD;
  localparam logic [7:0] MrkBytes32 = 8'hCE;
  localparam logic [7:0] MrkStr8    = 8'hD0;
  localparam logic [7:0] MrkStr16   = 8'hD1;
  localparam logic [7:0] MrkStr32   = 8'hD2;
  localparam logic [7:0] MrkList8   = 8'hD4;
  localparam logic [7:0] MrkList16  = 8'hD5;
  localparam logic [7:0] MrkList32  = 8'hD6;
  localparam logic [7:0] MrkMap8    = 8'hD8;
  localparam logic [7:0] MrkMap16   = 8'hD9;
  localparam logic [7:0] MrkMap32   = 8'hDA;
  localparam logic [7:0] MrkStruct8 = 8'hDC;
  localparam logic [7:0] MrkStruct16 = 8'hDD;
  localparam logic [7:0] TinyStr    = 8'h80;
  localparam logic [7:0] TinyList   = 8'h90;
  localparam logic [7:0] TinyMap    = 8'hA0;
  localparam logic [7:0] TinyStruct = 8'hB0;

  // one encoded token: bytes left aligned, first byte on top
  typedef struct packed {
    logic [WordWidth-1:0] bytes;
    logic [CntWidth-1:0]  cnt;
    logic                 err;
  } desc_t;

  // length header in the smallest form
  function automatic desc_t hdr_desc(logic [31:0] len, logic has_tiny, logic [7:0] tiny,
                                     logic [7:0] m8, logic [7:0] m16, logic [7:0] m32);
    desc_t d;
    d.err = 1'b0;
    if (has_tiny && (len[31:4] == '0)) begin
      d.bytes = {tiny | {4'h0, len[3:0]}, 64'h0};
      d.cnt   = 4'd1;
    end else if (len[31:8] == '0) begin
      d.bytes = {m8, len[7:0], 56'h0};
      d.cnt   = 4'd2;
    end else if (len[31:16] == '0) begin
      d.bytes = {m16, len[15:0], 48'h0};
      d.cnt   = 4'd3;
    end else begin
      d.bytes = {m32, len, 32'h0};
      d.cnt   = 4'd5;
    end
    return d;
  endfunction

endpackage

FILE: hw/rtl/pve_front.sv
// ----------------------------------------------------------------------------
// pve_front
// accepts tokens and turns each into a byte descriptor for the queue
// ----------------------------------------------------------------------------
module pve_front import pve_pkg::*; (
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CmdWidth-1:0]    cmd_i,
  input  logic                   bool_value_i,
  input  logic [63:0]            int_value_i,
  input  logic [63:0]            float_bits_i,
  input  logic [31:0]            length_i,
  input  logic [7:0]             signature_i,
  input  logic [7:0]             payload_byte_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output desc_t                  q_desc_o
);

  logic  known;
  desc_t d;

  always_comb begin
    known = 1'b1;
    d     = '0;
    case (cmd_e'(cmd_i))
      CMD_NULL: begin
        d.bytes = {MrkNull, 64'h0};
        d.cnt   = 4'd1;
      end
      CMD_BOOL: begin
        d.bytes = {(bool_value_i ? MrkTrue : MrkFalse), 64'h0};
        d.cnt   = 4'd1;
      end
      CMD_INT: begin
        // sign-extension checks pick the smallest form
        if ((int_value_i[63:7] == '0) ||
            ((int_value_i[63:4] == '1))) begin
          d.bytes = {int_value_i[7:0], 64'h0};
          d.cnt   = 4'd1;
        end else if ((int_value_i[63:7] == '0) || (int_value_i[63:7] == '1)) begin
          d.bytes = {MrkInt8, int_value_i[7:0], 56'h0};
          d.cnt   = 4'd2;
        end else if ((int_value_i[63:15] == '0) || (int_value_i[63:15] == '1)) begin
          d.bytes = {MrkInt16, int_value_i[15:0], 48'h0};
          d.cnt   = 4'd3;
        end else if ((int_value_i[63:31] == '0) || (int_value_i[63:31] == '1)) begin
          d.bytes = {MrkInt32, int_value_i[31:0], 32'h0};
          d.cnt   = 4'd5;
        end else begin
          d.bytes = {MrkInt64, int_value_i};
          d.cnt   = 4'd9;
        end
      end
      CMD_FLOAT: begin
        d.bytes = {MrkFloat, float_bits_i};
        d.cnt   = 4'd9;
      end
      CMD_STRING: d = hdr_desc(length_i, 1'b1, TinyStr, MrkStr8, MrkStr16, MrkStr32);
      CMD_BYTES:  d = hdr_desc(length_i, 1'b0, 8'h00, MrkBytes8, MrkBytes16, MrkBytes32);
      CMD_LIST:   d = hdr_desc(length_i, 1'b1, TinyList, MrkList8, MrkList16, MrkList32);
      CMD_MAP:    d = hdr_desc(length_i, 1'b1, TinyMap, MrkMap8, MrkMap16, MrkMap32);
      CMD_STRUCT: begin
        // header then signature; no marker exists above 16-bit counts
        if (length_i[31:16] != '0) begin
          d.err = 1'b1;
          d.cnt = 4'd1;
        end else if (length_i[15:4] == '0) begin
          d.bytes = {TinyStruct | {4'h0, length_i[3:0]}, signature_i, 56'h0};
          d.cnt   = 4'd2;
        end else if (length_i[15:8] == '0) begin
          d.bytes = {MrkStruct8, length_i[7:0], signature_i, 48'h0};
          d.cnt   = 4'd3;
        end else begin
          d.bytes = {MrkStruct16, length_i[15:0], signature_i, 40'h0};
          d.cnt   = 4'd4;
        end
      end
      CMD_RAW: begin
        d.bytes = {payload_byte_i, 64'h0};
        d.cnt   = 4'd1;
      end
      default: known = 1'b0;
    endcase
  end

  // unused kinds are taken and dropped
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && known;
  assign q_desc_o   = d;

endmodule

FILE: hw/rtl/pve_queue.sv
// ----------------------------------------------------------------------------
// pve_queue
// short descriptor queue between classifier and serializer
// ----------------------------------------------------------------------------
module pve_queue import pve_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output desc_t desc_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   fill_q, fill_d;

  assign full_o  = (fill_q == CntW'(Depth));
  assign valid_o = (fill_q != '0);
  assign desc_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (!push_i && pop_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

FILE: hw/rtl/pve_back.sv
// ----------------------------------------------------------------------------
// pve_back
// shifts a descriptor out a byte per ready cycle, reloading on the last byte
// ----------------------------------------------------------------------------
module pve_back import pve_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  desc_t                   q_desc_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [OutDataWidth-1:0] out_byte_o,
  output logic                    out_last_o,
  output logic                    out_err_o
);

  logic [WordWidth-1:0] shreg_q, shreg_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 err_q, err_d;
  logic                 take, load;

  assign out_valid_o = (cnt_q != '0);
  assign take        = out_valid_o && out_ready_i;
  assign load        = q_valid_i && ((cnt_q == '0) || (take && (cnt_q == 4'd1)));
  assign q_pop_o     = load;

  assign out_byte_o = shreg_q[WordWidth-1 -: OutDataWidth];
  assign out_last_o = (cnt_q == 4'd1);
  assign out_err_o  = err_q;

  always_comb begin
    shreg_d = shreg_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    if (load) begin
      shreg_d = q_desc_i.bytes;
      cnt_d   = q_desc_i.cnt;
      err_d   = q_desc_i.err;
    end else if (take) begin
      shreg_d = {shreg_q[WordWidth-ByteWidth-1:0], {ByteWidth{1'b0}}};
      cnt_d   = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      err_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
  end

endmodule

FILE: hw/rtl/packstream_value_encoder.sv
// ----------------------------------------------------------------------------
// packstream_value_encoder
// serializes one value token per request into its byte form, msb first
// ----------------------------------------------------------------------------
// Each request on the slave stream carries one token; the master stream
// returns its encoded bytes one per cycle unless m_axis_tready stalls it,
// tlast on the final byte. A token has one byte for null, bool, tiny ints and
// raw bytes, up to nine for 64-bit ints and floats, the serializer's single
// byte lane setting the pace. The classifier works in the cycle of the
// request and a short queue lets new tokens be taken while earlier ones are
// still being sent, so back-to-back tokens leave with no gap between them.
// A structure header with more than 65535 fields gives one beat with tuser
// set, data zero and tlast set. Kinds above raw byte are taken and produce
// nothing. No state is kept between tokens.
// ----------------------------------------------------------------------------
module packstream_value_encoder import pve_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // bool_value [0], int_value [64:1], float_bits [128:65], length [160:129],
  // signature [168:161], payload_byte [176:169], zero fill [183:177]
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // cmd [3:0]
  input  logic [CmdWidth-1:0]     s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // out_byte [7:0]
  output logic [OutDataWidth-1:0] m_axis_tdata,
  output logic                    m_axis_tlast,
  // error [0]
  output logic                    m_axis_tuser
);

  // queue between classifier and serializer
  logic  q_push, q_full, q_pop, q_valid;
  desc_t q_wdesc, q_rdesc;

  // classifier: decodes the token into marker plus payload bytes
  pve_front u_front (
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .cmd_i          (s_axis_tuser),
    .bool_value_i   (s_axis_tdata[0]),
    .int_value_i    (s_axis_tdata[64:1]),
    .float_bits_i   (s_axis_tdata[128:65]),
    .length_i       (s_axis_tdata[160:129]),
    .signature_i    (s_axis_tdata[168:161]),
    .payload_byte_i (s_axis_tdata[176:169]),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_desc_o       (q_wdesc)
  );

  pve_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (q_wdesc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .desc_o  (q_rdesc)
  );

  // serializer: holds the current token and shifts it out
  pve_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_desc_i    (q_rdesc),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

endmodule

FILE: test/pve_beat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pve_beat_checker
// watches both streams of the value encoder and checks every output beat
// ----------------------------------------------------------------------------
// Each accepted request is encoded here into the bytes it must produce. Each
// accepted output beat is compared with the oldest predicted beat. Mismatches
// and beats with nothing predicted are counted and handed to the top.
// ----------------------------------------------------------------------------
module pve_beat_checker import pve_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  input  logic [CmdWidth-1:0]     s_axis_tuser,
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic [OutDataWidth-1:0] m_axis_tdata,
  input  logic                    m_axis_tlast,
  input  logic                    m_axis_tuser,
  output int                      mismatch_cnt_o,
  output int                      pending_beats_o,
  output int                      checked_beats_o,
  output int                      error_beats_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } enc_beat_t;

  enc_beat_t expected_beats[$];

  initial begin
    mismatch_cnt_o  = 0;
    pending_beats_o = 0;
    checked_beats_o = 0;
    error_beats_o   = 0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] got_v);
    if (mismatch_cnt_o < 40) begin
      $display("[%0t] beat %0d: %s expected %h got %h", $time, checked_beats_o, what,
               exp_v, got_v);
    end
    mismatch_cnt_o++;
  endtask

  function automatic void push_byte(input logic [7:0] b);
    enc_beat_t e;
    e.data = b;
    e.last = 1'b0;
    e.err  = 1'b0;
    expected_beats.push_back(e);
  endfunction

  // value bytes, most significant first
  function automatic void push_be(input logic [63:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) begin
      push_byte(v[8*i +: 8]);
    end
  endfunction

  // length header in its smallest form
  function automatic void push_length(input logic [31:0] len, input logic has_tiny,
                                      input logic [7:0] tiny, input logic [7:0] m8,
                                      input logic [7:0] m16, input logic [7:0] m32);
    if (has_tiny && len < 16) begin
      push_byte(tiny + len[7:0]);
    end else if (len < 32'h100) begin
      push_byte(m8);
      push_be({32'h0, len}, 1);
    end else if (len < 32'h1_0000) begin
      push_byte(m16);
      push_be({32'h0, len}, 2);
    end else begin
      push_byte(m32);
      push_be({32'h0, len}, 4);
    end
  endfunction

  // true when v survives sign extension from its low n bits
  function automatic logic fits_signed(input logic [63:0] v, input int n);
    logic [63:0] ext;
    ext = v << (64 - n);
    ext = $signed(ext) >>> (64 - n);
    return ext == v;
  endfunction

  function automatic void encode_token(input logic [CmdWidth-1:0] cmd,
                                       input logic [InDataWidth-1:0] d);
    logic        bv;
    logic [63:0] iv;
    logic [63:0] fb;
    logic [31:0] len;
    logic [7:0]  sig;
    logic [7:0]  pay;
    int          first;
    enc_beat_t   e;
    bv    = d[0];
    iv    = d[64:1];
    fb    = d[128:65];
    len   = d[160:129];
    sig   = d[168:161];
    pay   = d[176:169];
    first = expected_beats.size();
    case (cmd_e'(cmd))
      CMD_NULL:  push_byte(MrkNull);
      CMD_BOOL:  push_byte(bv ? MrkTrue : MrkFalse);
      CMD_INT: begin
        // tiny ints run from -16 to 127 and are their own low byte
        if (fits_signed(iv, 8) && (!iv[7] || iv[7:4] == 4'hF)) begin
          push_byte(iv[7:0]);
        end else if (fits_signed(iv, 8)) begin
          push_byte(MrkInt8);
          push_be(iv, 1);
        end else if (fits_signed(iv, 16)) begin
          push_byte(MrkInt16);
          push_be(iv, 2);
        end else if (fits_signed(iv, 32)) begin
          push_byte(MrkInt32);
          push_be(iv, 4);
        end else begin
          push_byte(MrkInt64);
          push_be(iv, 8);
        end
      end
      CMD_FLOAT: begin
        push_byte(MrkFloat);
        push_be(fb, 8);
      end
      CMD_STRING: push_length(len, 1'b1, TinyStr, MrkStr8, MrkStr16, MrkStr32);
      CMD_BYTES:  push_length(len, 1'b0, 8'h00, MrkBytes8, MrkBytes16, MrkBytes32);
      CMD_LIST:   push_length(len, 1'b1, TinyList, MrkList8, MrkList16, MrkList32);
      CMD_MAP:    push_length(len, 1'b1, TinyMap, MrkMap8, MrkMap16, MrkMap32);
      CMD_STRUCT: begin
        if (len > 32'hFFFF) begin
          // no marker exists for this many fields: a lone error beat
          e.data = 8'h00;
          e.last = 1'b1;
          e.err  = 1'b1;
          expected_beats.push_back(e);
          return;
        end
        push_length(len, 1'b1, TinyStruct, MrkStruct8, MrkStruct16, 8'h00);
        push_byte(sig);
      end
      CMD_RAW:   push_byte(pay);
      default: ;
    endcase
    if (expected_beats.size() > first) begin
      expected_beats[expected_beats.size() - 1].last = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin
    enc_beat_t e;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_token(s_axis_tuser, s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat, data", 8'hxx, m_axis_tdata);
        end else begin
          e = expected_beats.pop_front();
          if (m_axis_tdata !== e.data) report_mismatch("data", e.data, m_axis_tdata);
          if (m_axis_tlast !== e.last) begin
            report_mismatch("tlast", {7'h00, e.last}, {7'h00, m_axis_tlast});
          end
          if (m_axis_tuser !== e.err) begin
            report_mismatch("error", {7'h00, e.err}, {7'h00, m_axis_tuser});
          end
          if (e.err) error_beats_o++;
        end
        checked_beats_o++;
      end
      pending_beats_o = expected_beats.size();
    end
  end

endmodule

FILE: test/packstream_value_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packstream_value_encoder_test
// stimulus and verdict for the value stream encoder
// ----------------------------------------------------------------------------
// A directed pass hits every token kind, the size boundaries of integers and
// length headers, the oversized structure and an unused kind. Then random
// tokens follow with random gaps on the request side and random stalls on the
// output side. The checker beside the block predicts and compares each beat.
// ----------------------------------------------------------------------------
module packstream_value_encoder_test;
  import pve_pkg::*;

  localparam int RandomTokens = 300;
  localparam int CycleLimit   = 250000;
  localparam int DrainCycles  = 40;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata;
  logic [CmdWidth-1:0]     s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    m_axis_tlast;
  logic                    m_axis_tuser;

  int mismatch_cnt;
  int pending_beats;
  int checked_beats;
  int error_beats;

  // idle-free stretches, redrawn every 25 requests
  logic send_calm;
  logic recv_calm;
  int   tokens_sent;
  int   unused_sent;
  int   cycle_cnt;

  packstream_value_encoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  pve_beat_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_beats_o(pending_beats),
    .checked_beats_o(checked_beats),
    .error_beats_o  (error_beats)
  );

  // clock, 20 ns period
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog against a hung stream
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats still pending", cycle_cnt, pending_beats);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // signed integer spread over all widths, boundaries now and then
  function automatic logic [63:0] rand_int();
    logic [63:0] v;
    int          k;
    k = $urandom_range(1, 64);
    v = rand64();
    v = $signed(v) >>> (64 - k);
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 9))
        0: v = -64'sd16;
        1: v = -64'sd17;
        2: v = 64'd127;
        3: v = 64'd128;
        4: v = -64'sd128;
        5: v = -64'sd129;
        6: v = 64'h7FFF_FFFF;
        7: v = 64'hFFFF_FFFF_8000_0000;
        8: v = 64'h8000_0000_0000_0000;
        default: v = 64'h7FFF_FFFF_FFFF_FFFF;
      endcase
    end
    return v;
  endfunction

  // length spread over all header forms
  function automatic logic [31:0] rand_length();
    logic [31:0] v;
    int          k;
    k = $urandom_range(0, 32);
    v = $urandom;
    if (k < 32) v = v & ((32'h1 << k) - 32'h1);
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 6))
        0: v = 32'd15;
        1: v = 32'd16;
        2: v = 32'd255;
        3: v = 32'd256;
        4: v = 32'hFFFF;
        5: v = 32'h1_0000;
        default: v = 32'hFFFF_FFFF;
      endcase
    end
    return v;
  endfunction

  // one request: value goes to the field the kind uses, byte_val to
  // signature or payload, all other fields random
  task automatic send_token(input logic [CmdWidth-1:0] cmd, input logic [63:0] value,
                            input logic [7:0] byte_val);
    logic        bv;
    logic [63:0] iv;
    logic [63:0] fb;
    logic [31:0] len;
    logic [7:0]  sig;
    logic [7:0]  pay;
    int          gap;
    bv  = 1'($urandom_range(0, 1));
    iv  = rand64();
    fb  = rand64();
    len = $urandom;
    sig = 8'($urandom_range(0, 255));
    pay = 8'($urandom_range(0, 255));
    case (cmd_e'(cmd))
      CMD_BOOL:  bv = value[0];
      CMD_INT:   iv = value;
      CMD_FLOAT: fb = value;
      CMD_STRING, CMD_BYTES, CMD_LIST, CMD_MAP: len = value[31:0];
      CMD_STRUCT: begin
        len = value[31:0];
        sig = byte_val;
      end
      CMD_RAW:   pay = byte_val;
      default: ;
    endcase
    gap = send_calm ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'h00, pay, sig, len, fb, iv, bv};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    if (cmd > CMD_RAW) unused_sent++;
    else tokens_sent++;
  endtask

  // output side: a fresh stall for every beat
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = recv_calm ? 0 : $urandom_range(0, 13);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // stimulus and verdict
  initial begin
    logic [CmdWidth-1:0] cmd;
    logic [63:0]         value;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    send_calm     = 1'b0;
    recv_calm     = 1'b0;
    tokens_sent   = 0;
    unused_sent   = 0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed pass
    send_token(CMD_NULL, 64'h0, 8'h00);
    send_token(CMD_BOOL, 64'h0, 8'h00);
    send_token(CMD_BOOL, 64'h1, 8'h00);
    send_token(CMD_INT, -64'sd16, 8'h00);                // lowest tiny int
    send_token(CMD_INT, -64'sd17, 8'h00);
    send_token(CMD_INT, 64'd127, 8'h00);                 // highest tiny int
    send_token(CMD_INT, 64'd128, 8'h00);
    send_token(CMD_INT, -64'sd129, 8'h00);
    send_token(CMD_INT, 64'd32768, 8'h00);
    send_token(CMD_INT, 64'hFFFF_FFFF_7FFF_FFFF, 8'h00); // just below 32-bit range
    send_token(CMD_INT, 64'h8000_0000_0000_0000, 8'h00);
    send_token(CMD_INT, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00);
    send_token(CMD_FLOAT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    send_token(CMD_FLOAT, 64'h0, 8'h00);
    send_token(CMD_STRING, 64'd15, 8'h00);
    send_token(CMD_STRING, 64'd16, 8'h00);
    send_token(CMD_BYTES, 64'd0, 8'h00);                 // bytes have no tiny form
    send_token(CMD_BYTES, 64'h1_0000, 8'h00);
    send_token(CMD_LIST, 64'd255, 8'h00);
    send_token(CMD_MAP, 64'hFFFF_FFFF, 8'h00);
    send_token(CMD_STRUCT, 64'd15, 8'hFF);
    send_token(CMD_STRUCT, 64'hFFFF, 8'h00);             // widest legal structure
    send_token(CMD_STRUCT, 64'h1_0000, 8'hA5);           // too many fields: error beat
    send_token(CMD_RAW, 64'h0, 8'hFF);
    send_token(4'hF, rand64(), 8'h00);                   // unused kind, no output

    // random pass, idle mode redrawn every 25 requests
    while (tokens_sent < 25 + RandomTokens) begin
      if ((tokens_sent + unused_sent) % 25 == 0) begin
        send_calm = ($urandom_range(0, 3) == 0);
        recv_calm = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 19) == 0) cmd = CmdWidth'($urandom_range(CMD_RAW + 1, 15));
      else cmd = CmdWidth'($urandom_range(CMD_NULL, CMD_RAW));
      case (cmd_e'(cmd))
        CMD_INT: value = rand_int();
        CMD_STRING, CMD_BYTES, CMD_LIST, CMD_MAP, CMD_STRUCT: value = {32'h0, rand_length()};
        default: value = rand64();
      endcase
      send_token(cmd, value, 8'($urandom_range(0, 255)));
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // drain, then a quiet stretch to catch stray beats
    while (pending_beats != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("tokens sent: %0d valid kinds, %0d unused kinds, in %0d cycles",
             tokens_sent, unused_sent, cycle_cnt);
    $display("beats checked: %0d, error beats among them: %0d, mismatches: %0d",
             checked_beats, error_beats, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_beats == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: packstream_value_encoder.f
hw/rtl/pve_pkg.sv
hw/rtl/pve_front.sv
hw/rtl/pve_queue.sv
hw/rtl/pve_back.sv
hw/rtl/packstream_value_encoder.sv
test/pve_beat_checker.sv
test/packstream_value_encoder_test.sv
